FILE: rtl/core/dtas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtas_pkg: shared types and calendar helpers
// Request and result formats, status codes, sequencer states, the month
// length table and the Gregorian leap rule.
// ----------------------------------------------------------------------------
package dtas_pkg;

  typedef logic [6:0] pivot_t;

  localparam logic [6:0] PIVOT_RESET = 7'd30;

  localparam logic [2:0] STATUS_OK           = 3'd0;
  localparam logic [2:0] STATUS_BAD_START_CLK = 3'd1;
  localparam logic [2:0] STATUS_BAD_RES_CLK   = 3'd2;
  localparam logic [2:0] STATUS_BAD_START_DATE = 3'd3;
  localparam logic [2:0] STATUS_BAD_RES_DATE   = 3'd4;

  localparam int ALU_W = 17;

  typedef struct packed {
    logic        mode;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;
    logic [15:0] offset_days;
    logic [9:0]  offset_years;
    logic [9:0]  offset_hours;
    logic [9:0]  offset_minutes;
    logic [9:0]  offset_seconds;
  } dtas_req_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [4:0]  result_hour;
    logic [5:0]  result_minute;
    logic [5:0]  result_second;
    logic [2:0]  status;
  } dtas_res_t;

  // shared subtract/compare unit result
  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             lt;
    logic             eq;
  } dtas_alu_t;

  // clock after subtracting the offset
  typedef struct packed {
    logic       ok;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       extra;
  } dtas_clk_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SEC,
    S_MIN,
    S_HOUR,
    S_DCHK,
    S_LEAP_CHK,
    S_DLEN,
    S_LEAP_ADD,
    S_WALK_ADD,
    S_WALK_SUB,
    S_LEAP_SUB,
    S_SUB_END,
    S_LEAP_FIN,
    S_SUB_FIN,
    S_DONE
  } dtas_state_t;

  localparam logic [4:0] MONTH_LEN [0:12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0
  };

  // y divisible by 25: floor(y * 41944 / 2^20) is exact for y below 2^15
  function automatic logic is_leap(logic [14:0] y);
    logic [30:0] prod;
    logic [10:0] q;
    logic [15:0] back;
    logic        div25;
    prod  = 31'(y) * 31'd41944;
    q     = prod[30:20];
    back  = {1'b0, q, 4'b0} + {2'b0, q, 3'b0} + {5'b0, q};
    div25 = (back == {1'b0, y});
    return (y[1:0] == 2'd0) && !(div25 && (y[3:0] != 4'd0));
  endfunction

  function automatic logic [4:0] month_days(logic leap, logic [3:0] m);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m == 4'd0 || m > 4'd12) return 5'd0;
    if (m == 4'd2 && leap) return 5'd29;
    return MONTH_LEN[idx];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dtas_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtas_alu: shared subtract and compare unit
// Gives a - b together with a < b and a == b; the sequencer reuses it for
// clock carries and for the month walk.
// ----------------------------------------------------------------------------
module dtas_alu (
  input  wire logic [dtas_pkg::ALU_W-1:0] a,
  input  wire logic [dtas_pkg::ALU_W-1:0] b,
  output dtas_pkg::dtas_alu_t             y
);
  import dtas_pkg::*;

  logic [ALU_W:0] wide;

  always_comb begin
    wide   = {1'b0, a} - {1'b0, b};
    y.diff = wide[ALU_W-1:0];
    y.lt   = wide[ALU_W];
    y.eq   = (a == b);
  end

endmodule
`default_nettype wire

FILE: rtl/core/dtas_borrow.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtas_borrow: clock subtraction
// Takes the offset off the start clock, each unit borrowing at most once,
// and flags a result outside the clock ranges.
// ----------------------------------------------------------------------------
module dtas_borrow (
  input  wire dtas_pkg::dtas_req_t req,
  output dtas_pkg::dtas_clk_t      clk_out
);
  import dtas_pkg::*;

  logic [10:0] ss, smi, sh, os, bm, bh;
  logic [10:0] sec_v, min_v, hour_v;
  logic        s_b, m_b, h_b, s_ok, m_ok, h_ok;

  always_comb begin
    ss  = 11'(req.start_second);
    smi = 11'(req.start_minute);
    sh  = 11'(req.start_hour);
    os  = 11'(req.offset_seconds);

    s_b   = ss < os;
    s_ok  = !s_b || (os <= ss + 11'd60);
    sec_v = s_b ? ss + 11'd60 - os : ss - os;

    bm    = 11'(req.offset_minutes) + 11'(s_b);
    m_b   = smi < bm;
    m_ok  = !m_b || (bm <= smi + 11'd60);
    min_v = m_b ? smi + 11'd60 - bm : smi - bm;

    bh     = 11'(req.offset_hours) + 11'(m_b);
    h_b    = sh < bh;
    h_ok   = !h_b || (bh <= sh + 11'd24);
    hour_v = h_b ? sh + 11'd24 - bh : sh - bh;

    clk_out.ok     = s_ok && m_ok && h_ok;
    clk_out.second = sec_v[5:0];
    clk_out.minute = min_v[5:0];
    clk_out.hour   = hour_v[4:0];
    clk_out.extra  = h_b;
  end

endmodule
`default_nettype wire

FILE: rtl/core/datetime_add_subtract_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// datetime_add_subtract_unit: Gregorian date and time offset
// Adds an offset of days, years, hours, minutes and seconds to a start date
// and time, or subtracts it, and returns the result with a status.
// ----------------------------------------------------------------------------
// One request at a time. After setup, when adding, the sequencer takes each
// carry of 60 seconds, 60 minutes and 24 hours out through the shared unit,
// one at a time; then the day walk steps through the months crossed one by
// one, and at every year boundary the leap flag of the new year is
// registered before the walk goes on. For large day offsets the month walk
// through the shared subtract/compare unit takes most of the time. The result
// sits in an output register, so the next request is taken while it waits.
// Errors return the start fields unchanged with a nonzero status; a start
// clock error goes from the start check straight to the done state.
// ----------------------------------------------------------------------------
module datetime_add_subtract_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire dtas_pkg::dtas_req_t req_data,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output dtas_pkg::dtas_res_t      res_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire dtas_pkg::pivot_t    cfg_data
);
  import dtas_pkg::*;

  dtas_state_t st, st_next;
  dtas_req_t   req;
  pivot_t      pivot;

  logic [10:0] acc, acc_next;
  logic [4:0]  carry, carry_next;
  logic [5:0]  extra, extra_next;
  logic [5:0]  cs, cs_next, cmi, cmi_next;
  logic [4:0]  ch, ch_next;
  logic [14:0] y, y_next;
  logic [3:0]  m, m_next;
  logic [16:0] d, d_next, left, left_next;
  logic        leap_q, leap_next;
  logic [2:0]  status, status_next;
  logic        res_load;

  logic [ALU_W-1:0] alu_a, alu_b;
  dtas_alu_t        alu;
  dtas_clk_t        bclk;
  logic [4:0]       len;

  dtas_alu u_alu (
    .a(alu_a),
    .b(alu_b),
    .y(alu)
  );

  dtas_borrow u_borrow (
    .req(req),
    .clk_out(bclk)
  );

  assign req_ready = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign len       = month_days(leap_q, m);

  always_comb begin
    unique case (st)
      S_SEC, S_MIN: begin
        alu_a = ALU_W'(acc);
        alu_b = ALU_W'(7'd60);
      end
      S_HOUR: begin
        alu_a = ALU_W'(acc);
        alu_b = ALU_W'(5'd24);
      end
      S_WALK_ADD: begin
        alu_a = d;
        alu_b = ALU_W'(len);
      end
      S_WALK_SUB: begin
        alu_a = left;
        alu_b = d;
      end
      S_SUB_END: begin
        alu_a = d;
        alu_b = left;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    st_next     = st;
    acc_next    = acc;
    carry_next  = carry;
    extra_next  = extra;
    cs_next     = cs;
    cmi_next    = cmi;
    ch_next     = ch;
    y_next      = y;
    m_next      = m;
    d_next      = d;
    left_next   = left;
    leap_next   = leap_q;
    status_next = status;
    res_load    = 1'b0;

    unique case (st)
      S_IDLE: begin
        if (req_valid) st_next = S_START;
      end
      S_START: begin
        status_next = STATUS_OK;
        if (req.start_hour > 5'd23 || req.start_minute > 6'd59 ||
            req.start_second > 6'd59) begin
          status_next = STATUS_BAD_START_CLK;
          st_next     = S_DONE;
        end else if (!req.mode) begin
          acc_next   = 11'(req.start_second) + 11'(req.offset_seconds);
          carry_next = '0;
          extra_next = '0;
          st_next    = S_SEC;
        end else if (!bclk.ok) begin
          status_next = STATUS_BAD_RES_CLK;
          st_next     = S_DONE;
        end else begin
          cs_next    = bclk.second;
          cmi_next   = bclk.minute;
          ch_next    = bclk.hour;
          extra_next = 6'(bclk.extra);
          st_next    = S_DCHK;
        end
      end
      S_SEC: begin
        if (!alu.lt) begin
          acc_next   = alu.diff[10:0];
          carry_next = carry + 5'd1;
        end else begin
          cs_next    = acc[5:0];
          acc_next   = 11'(req.start_minute) + 11'(req.offset_minutes) + 11'(carry);
          carry_next = '0;
          st_next    = S_MIN;
        end
      end
      S_MIN: begin
        if (!alu.lt) begin
          acc_next   = alu.diff[10:0];
          carry_next = carry + 5'd1;
        end else begin
          cmi_next = acc[5:0];
          acc_next = 11'(req.start_hour) + 11'(req.offset_hours) + 11'(carry);
          st_next  = S_HOUR;
        end
      end
      S_HOUR: begin
        if (!alu.lt) begin
          acc_next   = alu.diff[10:0];
          extra_next = extra + 6'd1;
        end else begin
          ch_next = acc[4:0];
          st_next = S_DCHK;
        end
      end
      S_DCHK: begin
        if (req.start_day == 5'd0 || req.start_month == 4'd0 ||
            req.start_month > 4'd12 ||
            (req.start_year > 14'd99 && req.start_year < 14'd1800)) begin
          status_next = STATUS_BAD_START_DATE;
          st_next     = S_DONE;
        end else begin
          // widen a two-digit year around the pivot
          if (req.start_year <= 14'd99) begin
            y_next = 15'(req.start_year) +
                     ((req.start_year > 14'(pivot)) ? 15'd1900 : 15'd2000);
          end else begin
            y_next = 15'(req.start_year);
          end
          st_next = S_LEAP_CHK;
        end
      end
      S_LEAP_CHK: begin
        leap_next = is_leap(y);
        st_next   = S_DLEN;
      end
      S_DLEN: begin
        m_next = req.start_month;
        if (req.start_day > month_days(leap_q, req.start_month)) begin
          status_next = STATUS_BAD_START_DATE;
          st_next     = S_DONE;
        end else if (!req.mode) begin
          y_next  = y + 15'(req.offset_years);
          d_next  = 17'(req.start_day) + 17'(req.offset_days) + 17'(extra);
          st_next = S_LEAP_ADD;
        end else begin
          left_next = 17'(req.offset_days) + 17'(extra);
          d_next    = 17'(req.start_day);
          st_next   = S_WALK_SUB;
        end
      end
      S_LEAP_ADD: begin
        leap_next = is_leap(y);
        st_next   = S_WALK_ADD;
      end
      S_WALK_ADD: begin
        if (m > 4'd12) begin
          m_next  = 4'd1;
          y_next  = y + 15'd1;
          st_next = S_LEAP_ADD;
        end else if (!alu.lt && !alu.eq) begin
          d_next = alu.diff;
          m_next = m + 4'd1;
        end else begin
          if (y[14]) status_next = STATUS_BAD_RES_DATE;
          st_next = S_DONE;
        end
      end
      S_WALK_SUB: begin
        if (!alu.lt) begin
          left_next = alu.diff;
          if (m > 4'd1) begin
            m_next = m - 4'd1;
            d_next = 17'(month_days(leap_q, m - 4'd1));
          end else begin
            // December does not depend on the leap flag
            m_next  = 4'd12;
            y_next  = y - 15'd1;
            d_next  = 17'(month_days(1'b0, 4'd12));
            st_next = S_LEAP_SUB;
          end
        end else begin
          st_next = S_SUB_END;
        end
      end
      S_LEAP_SUB: begin
        leap_next = is_leap(y);
        st_next   = S_WALK_SUB;
      end
      S_SUB_END: begin
        d_next  = alu.diff;
        y_next  = y - 15'(req.offset_years);
        st_next = S_LEAP_FIN;
      end
      S_LEAP_FIN: begin
        leap_next = is_leap(y);
        st_next   = S_SUB_FIN;
      end
      S_SUB_FIN: begin
        if (y < 15'd1800 || y[14]) begin
          status_next = STATUS_BAD_RES_DATE;
        end else if (m == 4'd2 && d == 17'd29 && !leap_q) begin
          d_next = 17'd28;
        end
        st_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!res_valid || res_ready) begin
          res_load = 1'b1;
          st_next  = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot <= PIVOT_RESET;
    end else if (cfg_valid) begin
      pivot <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req <= req_data;
    acc    <= acc_next;
    carry  <= carry_next;
    extra  <= extra_next;
    cs     <= cs_next;
    cmi    <= cmi_next;
    ch     <= ch_next;
    y      <= y_next;
    m      <= m_next;
    d      <= d_next;
    left   <= left_next;
    leap_q <= leap_next;
    status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data.status <= status;
      if (status == STATUS_OK) begin
        res_data.result_day    <= d[4:0];
        res_data.result_month  <= m;
        res_data.result_year   <= y[13:0];
        res_data.result_hour   <= ch;
        res_data.result_minute <= cmi;
        res_data.result_second <= cs;
      end else begin
        res_data.result_day    <= req.start_day;
        res_data.result_month  <= req.start_month;
        res_data.result_year   <= req.start_year;
        res_data.result_hour   <= req.start_hour;
        res_data.result_minute <= req.start_minute;
        res_data.result_second <= req.start_second;
      end
    end
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> st == S_START)
    else $error("accepted request did not start the sequencer");

  a_walk_add_month: assert property (@(posedge clk) disable iff (rst)
    st == S_WALK_ADD |-> m >= 4'd1 && m <= 4'd13)
    else $error("month out of range in forward walk");

  a_walk_sub_day: assert property (@(posedge clk) disable iff (rst)
    st == S_WALK_SUB |-> d != 17'd0 && m >= 4'd1 && m <= 4'd12)
    else $error("day or month out of range in backward walk");

  a_ok_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == STATUS_OK |->
      res_data.result_hour < 5'd24 && res_data.result_minute < 6'd60 &&
      res_data.result_second < 6'd60 && res_data.result_day != 5'd0 &&
      res_data.result_month >= 4'd1 && res_data.result_month <= 4'd12)
    else $error("ok status with an invalid date or time");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    st == S_DONE && (!res_valid || res_ready) |=> res_valid && st == S_IDLE)
    else $error("finished request not moved to the output register");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: datetime_add_subtract_unit
// Drives date/time offset requests through the valid/ready request channel,
// predicts every result with an independent calendar model, and compares each
// accepted result field by field. Covers directed corner dates, several
// century pivot settings, a long result-side stall and random traffic under
// three idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtas_pkg::*;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_SUB = 1'b1;

  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int DRAIN_CYCLES = 2500;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 100;
  localparam int PHASE_ITEMS  = 530;

  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  dtas_req_t req_data;
  logic      res_valid;
  logic      res_ready = 1'b0;
  dtas_res_t res_data;
  logic      cfg_valid;
  logic      cfg_ready;
  pivot_t    cfg_data;

  pivot_t    pivot_model = PIVOT_RESET;
  dtas_res_t pending_results [$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_requests = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        error_count = 0;
  int        result_index = 0;
  int        cycle_count = 0;

  datetime_add_subtract_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("datetime_add_subtract_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- calendar
  function automatic bit gregorian_leap(int y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 == 0 && y % 400 != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int month_length(int y, int m);
    if (m < 1 || m > 12) return 0;
    if (m == 2 && gregorian_leap(y)) return 29;
    return MONTH_DAYS[m - 1];
  endfunction

  function automatic bit clock_valid(int h, int mi, int s);
    return h >= 0 && h <= 23 && mi >= 0 && mi <= 59 && s >= 0 && s <= 59;
  endfunction

  function automatic int widen_year(int y, int p);
    if (y > 99) return y;
    return y + ((y > p) ? 1900 : 2000);
  endfunction

  function automatic dtas_res_t offset_datetime(dtas_req_t r, pivot_t pivot);
    int sd, sm, sy, sh, smi, ss, od, oy, oh, omi, os;
    int ch, cmi, cs, extra, wy, d, m, y, t, bm, bh, left, len;
    logic [2:0] st;
    dtas_res_t o;
    sd = int'(r.start_day);        sm = int'(r.start_month);
    sy = int'(r.start_year);       sh = int'(r.start_hour);
    smi = int'(r.start_minute);    ss = int'(r.start_second);
    od = int'(r.offset_days);      oy = int'(r.offset_years);
    oh = int'(r.offset_hours);     omi = int'(r.offset_minutes);
    os = int'(r.offset_seconds);
    ch = 0; cmi = 0; cs = 0; extra = 0; wy = sy; d = 0; m = 0; y = 0;
    st = STATUS_OK;
    if (!clock_valid(sh, smi, ss)) begin
      st = STATUS_BAD_START_CLK;
    end else begin
      if (r.mode == MODE_ADD) begin
        t = ss + os;
        cs = t % 60;
        t = smi + omi + t / 60;
        cmi = t % 60;
        t = sh + oh + t / 60;
        ch = t % 24;
        extra = t / 24;
      end else begin
        // each unit borrows at most once; only one day is ever borrowed
        bm = omi;
        bh = oh;
        cs = ss;
        if (cs < os) begin
          cs += 60;
          bm++;
        end
        cs -= os;
        cmi = smi;
        if (cmi < bm) begin
          cmi += 60;
          bh++;
        end
        cmi -= bm;
        ch = sh;
        if (ch < bh) begin
          ch += 24 - bh;
          extra = 1;
        end else begin
          ch -= bh;
        end
        if (!clock_valid(ch, cmi, cs)) st = STATUS_BAD_RES_CLK;
      end
      if (st == STATUS_OK) begin
        if (sd < 1 || sm < 1 || sm > 12 || (sy > 99 && sy < 1800)) begin
          st = STATUS_BAD_START_DATE;
        end else begin
          wy = widen_year(sy, int'(pivot));
          if (sd > month_length(wy, sm)) st = STATUS_BAD_START_DATE;
        end
      end
      if (st == STATUS_OK) begin
        m = sm;
        y = wy;
        if (r.mode == MODE_ADD) begin
          // years first, so the walk sees the leap rule of the shifted years
          y += oy;
          d = sd + od + extra;
          forever begin
            if (m > 12) begin
              m -= 12;
              y++;
            end
            len = month_length(y, m);
            if (d > len) begin
              d -= len;
              m++;
            end else begin
              break;
            end
          end
          if (y > 16383) st = STATUS_BAD_RES_DATE;
        end else begin
          left = od + extra;
          d = sd;
          while (left >= d) begin
            left -= d;
            if (m > 1) begin
              m--;
            end else begin
              y--;
              m = 12;
            end
            d = month_length(y, m);
          end
          d -= left;
          y -= oy;
          if (y < 1800 || y > 16383) st = STATUS_BAD_RES_DATE;
          else if (m == 2 && d == 29 && !gregorian_leap(y)) d = 28;
        end
      end
    end
    if (st == STATUS_OK) begin
      o.result_day    = d[4:0];
      o.result_month  = m[3:0];
      o.result_year   = y[13:0];
      o.result_hour   = ch[4:0];
      o.result_minute = cmi[5:0];
      o.result_second = cs[5:0];
    end else begin
      // pass the start fields through, year not widened
      o.result_day    = r.start_day;
      o.result_month  = r.start_month;
      o.result_year   = r.start_year;
      o.result_hour   = r.start_hour;
      o.result_minute = r.start_minute;
      o.result_second = r.start_second;
    end
    o.status = st;
    return o;
  endfunction

  // ---------------------------------------------------------------- requests
  function automatic dtas_req_t make_request(logic mode, int day, int month, int year,
                                             int hour, int minute, int second, int days,
                                             int years, int hours, int minutes, int seconds);
    dtas_req_t r;
    r.mode           = mode;
    r.start_day      = 5'(day);
    r.start_month    = 4'(month);
    r.start_year     = 14'(year);
    r.start_hour     = 5'(hour);
    r.start_minute   = 6'(minute);
    r.start_second   = 6'(second);
    r.offset_days    = 16'(days);
    r.offset_years   = 10'(years);
    r.offset_hours   = 10'(hours);
    r.offset_minutes = 10'(minutes);
    r.offset_seconds = 10'(seconds);
    return r;
  endfunction

  function automatic dtas_req_t random_request();
    dtas_req_t r;
    int sel, yr, mo;
    r.mode = 1'($urandom_range(1));
    if ($urandom_range(99) < 85) begin
      r.start_hour   = 5'($urandom_range(23));
      r.start_minute = 6'($urandom_range(59));
      r.start_second = 6'($urandom_range(59));
    end else begin
      r.start_hour   = 5'($urandom_range(31));
      r.start_minute = 6'($urandom_range(63));
      r.start_second = 6'($urandom_range(63));
    end
    if ($urandom_range(99) < 88) begin
      sel = $urandom_range(99);
      if (sel < 30) yr = $urandom_range(99);
      else if (sel < 92) yr = $urandom_range(9999, 1800);
      else yr = $urandom_range(16383, 10000);
      mo = $urandom_range(12, 1);
      r.start_year  = 14'(yr);
      r.start_month = 4'(mo);
      r.start_day   = 5'($urandom_range(month_length(widen_year(yr, int'(pivot_model)), mo),
                                        1));
    end else begin
      r.start_year  = 14'($urandom_range(16383));
      r.start_month = 4'($urandom_range(15));
      r.start_day   = 5'($urandom_range(31));
    end
    // mostly short day offsets: the month walk steps through each month crossed
    sel = $urandom_range(99);
    if (sel < 80) r.offset_days = 16'($urandom_range(400));
    else if (sel < 92) r.offset_days = 16'($urandom_range(4000));
    else r.offset_days = 16'($urandom_range(65535));
    r.offset_years = ($urandom_range(99) < 80) ? 10'($urandom_range(30)) :
                                                 10'($urandom_range(1023));
    if ($urandom_range(99) < 65) begin
      r.offset_hours   = 10'($urandom_range(23));
      r.offset_minutes = 10'($urandom_range(59));
      r.offset_seconds = 10'($urandom_range(59));
    end else begin
      r.offset_hours   = 10'($urandom_range(1023));
      r.offset_minutes = 10'($urandom_range(1023));
      r.offset_seconds = 10'($urandom_range(1023));
    end
    return r;
  endfunction

  task automatic send_request(input dtas_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_results.push_back(offset_datetime(r, pivot_model));
  endtask

  // drop valid and hold until every predicted result has been taken
  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_pivot(input pivot_t v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    pivot_model = v;
  endtask

  // ---------------------------------------------------------------- results
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      // start a long stall on the result side
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    if (error_count < MAX_REPORTS)
      $display("result %0d %s: got %0d, predicted %0d", result_index, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    dtas_res_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", int'(res_data.status), 0);
      end else begin
        want = pending_results.pop_front();
        if (res_data.result_day !== want.result_day)
          report_mismatch("result_day", int'(res_data.result_day),
                          int'(want.result_day));
        if (res_data.result_month !== want.result_month)
          report_mismatch("result_month", int'(res_data.result_month),
                          int'(want.result_month));
        if (res_data.result_year !== want.result_year)
          report_mismatch("result_year", int'(res_data.result_year),
                          int'(want.result_year));
        if (res_data.result_hour !== want.result_hour)
          report_mismatch("result_hour", int'(res_data.result_hour),
                          int'(want.result_hour));
        if (res_data.result_minute !== want.result_minute)
          report_mismatch("result_minute", int'(res_data.result_minute),
                          int'(want.result_minute));
        if (res_data.result_second !== want.result_second)
          report_mismatch("result_second", int'(res_data.result_second),
                          int'(want.result_second));
        if (res_data.status !== want.status)
          report_mismatch("status", int'(res_data.status), int'(want.status));
      end
      result_index++;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed_cases();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_request(make_request(MODE_ADD, 1, 1, 2000, 0, 0, 0, 0, 0, 0, 0, 0));
    // Feb 29 shifted into a common year rolls to Mar 1; subtracting clamps
    send_request(make_request(MODE_ADD, 29, 2, 2024, 12, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_request(MODE_SUB, 29, 2, 2024, 12, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_request(MODE_SUB, 1, 3, 2024, 0, 0, 0, 1, 1, 0, 0, 0));
    send_request(make_request(MODE_ADD, 31, 12, 9999, 23, 59, 59, 65535, 1023, 1023, 1023, 1023));
    send_request(make_request(MODE_SUB, 31, 12, 16383, 23, 59, 59, 65535, 0, 23, 59, 59));
    send_request(make_request(MODE_SUB, 1, 1, 2000, 0, 0, 0, 0, 0, 0, 0, 1));
    // result year out of range at both ends
    send_request(make_request(MODE_SUB, 1, 1, 1800, 0, 0, 0, 1, 0, 0, 0, 0));
    send_request(make_request(MODE_SUB, 1, 1, 2000, 0, 0, 0, 0, 1023, 0, 0, 0));
    send_request(make_request(MODE_ADD, 1, 1, 16383, 0, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_request(MODE_ADD, 31, 12, 16383, 23, 59, 59, 0, 0, 0, 0, 1));
    // bad start clock
    send_request(make_request(MODE_ADD, 1, 1, 2000, 24, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_SUB, 1, 1, 2000, 0, 60, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_ADD, 1, 1, 2000, 31, 63, 63, 0, 0, 0, 0, 0));
    // bad result clock when subtracting
    send_request(make_request(MODE_SUB, 1, 1, 2000, 0, 0, 0, 0, 0, 0, 0, 1023));
    send_request(make_request(MODE_SUB, 1, 1, 2000, 0, 0, 0, 0, 0, 1023, 1023, 0));
    // bad start dates, and a two-digit leap day that is valid
    send_request(make_request(MODE_ADD, 0, 1, 2000, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_ADD, 1, 0, 2000, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_ADD, 31, 15, 2000, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_SUB, 1, 13, 1799, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_ADD, 1, 1, 100, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_ADD, 31, 4, 2021, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_SUB, 29, 2, 1900, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_ADD, 29, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // a start clock error outranks a bad date, a result clock error too
    send_request(make_request(MODE_SUB, 0, 0, 1799, 24, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(MODE_SUB, 0, 0, 1799, 0, 0, 0, 0, 0, 0, 0, 1023));
    wait_for_results();
  endtask

  task automatic test_century_pivot();
    pivot_t settings [4];
    int p;
    settings = '{7'd0, 7'd99, 7'd127, pivot_t'($urandom_range(127))};
    send_idle_pct = 10;
    recv_idle_pct = 10;
    foreach (settings[i]) begin
      write_pivot(settings[i]);
      p = int'(settings[i]);
      if (p > 98) p = 98;
      send_request(make_request(MODE_ADD, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(MODE_ADD, 31, 12, 99, 0, 0, 0, 1, 0, 0, 0, 0));
      // probe the Feb length at the pivot year and the next (both sides of a pivot below 99)
      send_request(make_request(MODE_SUB, 1, 3, p, 0, 0, 0, 1, 0, 0, 0, 0));
      send_request(make_request(MODE_SUB, 1, 3, p + 1, 0, 0, 0, 1, 0, 0, 0, 0));
      send_request(make_request(MODE_ADD, 29, 2, 96, 0, 0, 0, 0, 0, 0, 0, 0));
      wait_for_results();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    // keep offering while results are held back, so the input stalls
    repeat (8) send_request(random_request());
    wait_for_results();
    repeat (8) send_request(random_request());
    wait_for_results();
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct);
    write_pivot(pivot_t'($urandom_range(127)));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (PHASE_ITEMS) send_request(random_request());
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    run_random_phase(30, 79);
    run_random_phase(79, 30);
    run_random_phase(0, 0);
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_century_pivot();
    test_backpressure();
    test_random_traffic();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("datetime_add_subtract_unit: match");
    end else begin
      $display("datetime_add_subtract_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/dtas_pkg.sv
rtl/core/dtas_alu.sv
rtl/core/dtas_borrow.sv
rtl/core/datetime_add_subtract_unit.sv
verif/testbench.sv
